>>> rtl/ffba_pkg.sv
package ffba_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 24;
  localparam int HDR_W      = 8;
  localparam int BRK_W      = SIZE_W + 1;
  localparam int ST_W       = 2;
  localparam int CIDX_W     = 2;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOMEM   = 2'd1;
  localparam logic [ST_W-1:0] ST_UNKNOWN = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CIDX_W-1:0] CFG_HEAP_BASE    = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_HEAP_LIMIT   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_HEADER_BYTES = 2'd2;

  localparam logic [SIZE_W-1:0] HEAP_LIMIT_RST   = 24'd65536;
  localparam logic [HDR_W-1:0]  HEADER_BYTES_RST = 8'd24;

  typedef struct packed {
    logic load;
    logic scan;
    logic app_calc;
    logic app_commit;
    logic emit_hit;
    logic emit_miss;
    logic emit_null;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic null_free;
    logic hit;
    logic miss;
  } stat_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] bytes;
    logic              free;
  } entry_t;

endpackage

>>> rtl/first_fit_block_allocator.sv
// Channel   Transfer when              Payload
// in        start & !busy              in_opcode, in_request_size, in_payload_address
// out       out_valid (one cycle)      out_result_address, out_block_size, out_status
// cfg       cfg_valid & cfg_ready      cfg_index, cfg_data
//
// One item at a time. The block table is a memory read one entry per cycle while
// scanning; a free or a hit ends in the scan, and an allocate that misses goes on
// through an append state and a commit state before its result.
// Reset is synchronous, active low, and needs no clearing pass: the table is
// only read below its fill count. The receiver cannot stall; cfg_ready is always high.
module first_fit_block_allocator import ffba_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_opcode,
  input  logic [SIZE_W-1:0] in_request_size,
  input  logic [ADDR_W-1:0] in_payload_address,
  output logic              out_valid,
  output logic [ADDR_W-1:0] out_result_address,
  output logic [SIZE_W-1:0] out_block_size,
  output logic [ST_W-1:0]   out_status,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  ffba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  ffba_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_valid & cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_opcode          (in_opcode),
    .in_request_size    (in_request_size),
    .in_payload_address (in_payload_address),
    .out_valid          (out_valid),
    .out_result_address (out_result_address),
    .out_block_size     (out_block_size),
    .out_status         (out_status)
  );

endmodule

>>> rtl/ffba_ctrl.sv
module ffba_ctrl import ffba_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_APPEND = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.null_free) begin
          cmd.emit_null = 1'b1;
          state_nxt     = S_IDLE;
        end else if (stat.hit) begin
          cmd.emit_hit = 1'b1;
          state_nxt    = S_IDLE;
        end else if (stat.miss) begin
          if (stat.is_free) begin
            cmd.emit_miss = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_APPEND;
          end
        end
      end
      S_APPEND: begin
        cmd.app_calc = 1'b1;
        state_nxt    = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.app_commit = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> rtl/ffba_dp.sv
module ffba_dp import ffba_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0] cfg_data,
  input  logic              in_opcode,
  input  logic [SIZE_W-1:0] in_request_size,
  input  logic [ADDR_W-1:0] in_payload_address,
  output logic              out_valid,
  output logic [ADDR_W-1:0] out_result_address,
  output logic [SIZE_W-1:0] out_block_size,
  output logic [ST_W-1:0]   out_status
);

  entry_t mem [MAX_BLOCKS];

  logic [ADDR_W-1:0] base_r;
  logic [SIZE_W-1:0] limit_r;
  logic [HDR_W-1:0]  hdr_r;

  logic              op_r;
  logic [SIZE_W-1:0] want_r;
  logic [ADDR_W-1:0] paddr_r;
  logic [BRK_W-1:0]  need_r;

  logic [CNT_W-1:0]  count_r;
  logic [BRK_W-1:0]  brk_r;
  logic [CNT_W-1:0]  idx_r;
  logic              rd_vld_r;
  logic [IDX_W-1:0]  rd_idx_r;
  entry_t            rd_entry_r;

  logic [ADDR_W-1:0] app_start_r;
  logic              app_ok_r;

  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [SIZE_W-1:0] out_size_r, out_size_nxt;
  logic [ST_W-1:0]   out_st_r, out_st_nxt;

  logic              done_issue;
  logic              issue;
  logic              entry_hit;
  logic [ADDR_W-1:0] rd_payload;
  logic [BRK_W:0]    app_sum;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;

  assign done_issue = (idx_r >= count_r);
  assign issue      = cmd.scan && !done_issue;
  assign rd_payload = rd_entry_r.start + {{(ADDR_W-HDR_W){1'b0}}, hdr_r};

  always_comb begin
    if (op_r == OP_ALLOC) begin
      entry_hit = rd_vld_r && rd_entry_r.free && (rd_entry_r.bytes >= want_r);
    end else begin
      entry_hit = rd_vld_r && (rd_payload == paddr_r);
    end
  end

  assign stat.is_free   = (op_r == OP_FREE);
  assign stat.null_free = (op_r == OP_FREE) && (paddr_r == '0);
  assign stat.hit       = entry_hit;
  assign stat.miss      = done_issue && !entry_hit;

  assign app_sum = {1'b0, brk_r} + {1'b0, need_r};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_idx_r;
    mem_wdata = '{start: rd_entry_r.start, bytes: rd_entry_r.bytes,
                  free: (op_r == OP_FREE)};
    if (cmd.emit_hit) begin
      mem_we = 1'b1;
    end else if (cmd.app_commit && app_ok_r) begin
      mem_we    = 1'b1;
      mem_waddr = count_r[IDX_W-1:0];
      mem_wdata = '{start: app_start_r, bytes: want_r, free: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_entry_r <= mem[idx_r[IDX_W-1:0]];
    end
  end

  always_comb begin
    out_valid_nxt = cmd.emit_hit | cmd.emit_miss | cmd.emit_null | cmd.app_commit;
    out_addr_nxt  = '0;
    out_size_nxt  = '0;
    out_st_nxt    = ST_OK;
    if (cmd.emit_hit) begin
      out_addr_nxt = (op_r == OP_ALLOC) ? rd_payload : '0;
      out_size_nxt = rd_entry_r.bytes;
    end else if (cmd.emit_miss) begin
      out_st_nxt = ST_UNKNOWN;
    end else if (cmd.app_commit) begin
      if (app_ok_r) begin
        out_addr_nxt = app_start_r + {{(ADDR_W-HDR_W){1'b0}}, hdr_r};
        out_size_nxt = want_r;
      end else begin
        out_st_nxt = ST_NOMEM;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      limit_r     <= HEAP_LIMIT_RST;
      hdr_r       <= HEADER_BYTES_RST;
      count_r     <= '0;
      brk_r       <= '0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEAP_BASE:    base_r  <= cfg_data;
          CFG_HEAP_LIMIT:   limit_r <= cfg_data[SIZE_W-1:0];
          CFG_HEADER_BYTES: hdr_r   <= cfg_data[HDR_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        idx_r    <= '0;
        rd_vld_r <= 1'b0;
      end else begin
        rd_vld_r <= issue;
        if (issue) begin
          idx_r <= idx_r + 1'b1;
        end
      end
      if (cmd.app_commit && app_ok_r) begin
        count_r <= count_r + 1'b1;
        brk_r   <= app_sum[BRK_W-1:0];
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_opcode;
      want_r  <= in_request_size;
      paddr_r <= in_payload_address;
      need_r  <= {{(BRK_W-HDR_W){1'b0}}, hdr_r} + {1'b0, in_request_size};
    end
    if (issue) begin
      rd_idx_r <= idx_r[IDX_W-1:0];
    end
    if (cmd.app_calc) begin
      app_start_r <= base_r + {{(ADDR_W-BRK_W){1'b0}}, brk_r};
      app_ok_r    <= (count_r != CNT_W'(MAX_BLOCKS)) &&
                     (app_sum <= {2'b00, limit_r});
    end
    out_addr_r <= out_addr_nxt;
    out_size_r <= out_size_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_result_address = out_addr_r;
  assign out_block_size     = out_size_r;
  assign out_status         = out_st_r;

endmodule

>>> rtl/ffba_checker.sv
module ffba_checker import ffba_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [ADDR_W-1:0] out_result_address,
  input logic [SIZE_W-1:0] out_block_size,
  input logic [ST_W-1:0]   out_status
);

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after transfer");

  a_result_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) && !busy)
    else $error("result without item in flight");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("more than one result per item");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_UNKNOWN || out_status == ST_NOMEM) |->
      out_result_address == '0 && out_block_size == '0)
    else $error("failed request carries payload");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_NOMEM ||
      out_status == ST_UNKNOWN)
    else $error("undefined status code");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_result_address (out_result_address),
  .out_block_size     (out_block_size),
  .out_status         (out_status)
);
